/* sv/mat_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers for the matrix add/sub/mul/transpose block.
// No dependencies; imported by mat_ctrl, mat_dp and the top level.
package mat_pkg;

    localparam int MAX_DIM = 16;
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);

    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [2:0] SEC_SUM  = 3'd0;
    localparam logic [2:0] SEC_DIFF = 3'd1;
    localparam logic [2:0] SEC_PROD = 3'd2;
    localparam logic [2:0] SEC_TR_A = 3'd3;
    localparam logic [2:0] SEC_TR_B = 3'd4;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         section;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic issue;
        logic load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bad;
        logic last;
        logic busy;
        logic out_free;
    } dp_stat_t;

    // Saturate a dimension register to MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [4:0] d);
        if (int'(d) > MAX_DIM)
            return DIM_W'(MAX_DIM);
        else
            return DIM_W'(d);
    endfunction

    function automatic logic below(input logic [3:0] idx, input logic [DIM_W-1:0] dim);
        return int'(idx) < int'(dim);
    endfunction

endpackage

/* sv/mat_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences one read word through issue, drain and output.
// Depends on mat_pkg for command and status structs.
module mat_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_op,
    output logic              req_ready,
    input  mat_pkg::dp_stat_t stat,
    output mat_pkg::dp_cmd_t  cmd
);
    import mat_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = req_valid && req_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_op == OP_READ)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                // a rejected read goes straight out with status set
                if (stat.bad)
                    state_next = ST_DONE;
                else
                begin
                    cmd.issue = 1'b1;
                    if (stat.last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

/* sv/mat_dp.sv */
`timescale 1ns / 1ps
// Datapath: dimension registers, the two matrix memories, multiply-accumulate and output word.
// Depends on mat_pkg for item types, codes and helpers.
module mat_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mat_pkg::in_item_t   req,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [4:0]          cfg_data,
    input  mat_pkg::dp_cmd_t    cmd,
    output mat_pkg::dp_stat_t   stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mat_pkg::out_item_t  rsp
);
    import mat_pkg::*;

    logic [DIM_W-1:0] nr_reg, nc_reg;

    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];

    logic [2:0]        sec_reg;
    logic [IDX_W-1:0]  r_reg, c_reg, k_reg;
    logic [DIM_W-1:0]  len_reg;
    logic              bad_reg;
    logic [31:0]       rd_a_reg, rd_b_reg, prod_reg, acc_reg;
    logic              rd_v_reg, mul_v_reg;
    logic              rsp_valid_reg;
    out_item_t         rsp_reg;

    logic [IDX_W-1:0]  req_r, req_c;
    logic              wr_ok, bad_next;
    logic [DIM_W-1:0]  len_next;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic [31:0]       prod_next;

    assign req_r = IDX_W'(req.row);
    assign req_c = IDX_W'(req.col);
    assign wr_ok = below(req.row, nr_reg) && below(req.col, nc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nr_reg <= DIM_W'(1);
            nc_reg <= DIM_W'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_ROWS)
                nr_reg <= eff_dim(cfg_data);
            else if (cfg_index == REG_COLS)
                nc_reg <= eff_dim(cfg_data);
        end
    end

    always_comb
    begin
        bad_next = 1'b1;
        len_next = DIM_W'(1);
        unique case (req.section)
            SEC_SUM, SEC_DIFF:
                bad_next = !wr_ok;
            SEC_PROD:
            begin
                bad_next = !(nr_reg == nc_reg && below(req.row, nr_reg)
                             && below(req.col, nr_reg));
                len_next = nc_reg;
            end
            SEC_TR_A, SEC_TR_B:
                bad_next = !(below(req.row, nc_reg) && below(req.col, nr_reg));
            default:
                bad_next = 1'b1;
        endcase
    end

    always_comb
    begin
        unique case (sec_reg)
            SEC_PROD:
            begin
                addr_a = {r_reg, k_reg};
                addr_b = {k_reg, c_reg};
            end
            SEC_TR_A, SEC_TR_B:
            begin
                addr_a = {c_reg, r_reg};
                addr_b = {c_reg, r_reg};
            end
            default:
            begin
                addr_a = {r_reg, c_reg};
                addr_b = {r_reg, c_reg};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && req.operation == OP_WRITE_A && wr_ok)
            mem_a[{req_r, req_c}] <= req.value;
        if (cmd.issue)
            rd_a_reg <= mem_a[addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && req.operation == OP_WRITE_B && wr_ok)
            mem_b[{req_r, req_c}] <= req.value;
        if (cmd.issue)
            rd_b_reg <= mem_b[addr_b];
    end

    always_comb
    begin
        unique case (sec_reg)
            SEC_SUM:  prod_next = rd_a_reg + rd_b_reg;
            SEC_DIFF: prod_next = rd_a_reg - rd_b_reg;
            SEC_PROD: prod_next = rd_a_reg * rd_b_reg;
            SEC_TR_A: prod_next = rd_a_reg;
            SEC_TR_B: prod_next = rd_b_reg;
            default:  prod_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sec_reg <= req.section;
            r_reg   <= req_r;
            c_reg   <= req_c;
            len_reg <= len_next;
            bad_reg <= bad_next;
        end
        if (rd_v_reg)
            prod_reg <= prod_next;
        // clear on start, add each registered term
        if (cmd.start)
            acc_reg <= '0;
        else if (mul_v_reg)
            acc_reg <= acc_reg + prod_reg;
        if (cmd.load)
            rsp_reg <= '{result: acc_reg, status: bad_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
                k_reg <= '0;
            else if (cmd.issue)
                k_reg <= k_reg + IDX_W'(1);
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
            if (cmd.load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign stat.bad      = bad_reg;
    assign stat.last     = (DIM_W'(k_reg) + DIM_W'(1)) == len_reg;
    assign stat.busy     = rd_v_reg || mul_v_reg;
    assign stat.out_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* sv/matrix_add_sub_mul_transpose.sv */
`timescale 1ns / 1ps
// Top level of the integer matrix unit: sum, difference, product, transposes.
// Depends on mat_pkg, mat_ctrl and mat_dp.
//
// Channels: req (valid/ready) carries one word: operation, section, row, col, value.
// A write word stores one element of the first or second matrix in the cycle it is
// accepted and returns nothing; writes outside rows x cols are dropped. A read word
// returns one rsp word (result, status) on the rsp valid/ready channel.
// cfg (valid/ready, always ready) sets rows (index 0) and cols (index 1); values above
// MAX_DIM saturate. Write cfg only while no read is in flight.
// Sequence: a read word is accepted, then issues one read of each memory per term (cols
// terms for a product, one for other sections), drains while the registered memory read
// and term stages empty, and loads the output register; a rejected read skips issue and
// drain. req_ready returns in the same cycle as rsp_valid. The product rate is set by
// the single read port of each matrix memory: one multiply-add per cycle. Write words
// are taken every cycle while idle.
// Reset clears control and sets rows = cols = 1; matrix contents are undefined until
// written. If rsp stalls, the finished word holds in the output register while the next
// word may still be accepted; a new read waits at its end until the register frees.
module matrix_add_sub_mul_transpose (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mat_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mat_pkg::out_item_t rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data
);
    import mat_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.operation),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mat_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
